// ===== src/pkar_pkg.sv =====
package pkar_pkg;

  localparam logic [1:0] KIND_CHECK  = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_MAX     = 2'd1;
  localparam logic [1:0] REG_WINDOW  = 2'd2;

  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [31:0] now;
    logic        hit;
    logic [15:0] hit_count;
    logic [31:0] hit_start;
    logic [31:0] min_start;
  } scan_t;

  typedef struct packed {
    logic        en;
    logic        key_we;
    logic [15:0] count;
    logic [31:0] start;
  } wr_t;

endpackage

// ===== src/pkar_cell.sv =====
module pkar_cell #(
  parameter int TABLE_ENTRIES = 256,
  parameter int KEY_BITS      = 64,
  parameter int IDX           = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] used_cnt,
  input  pkar_pkg::scan_t                    tok_i,
  input  logic [KEY_BITS-1:0]                key_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   hit_idx_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   min_idx_i,
  output pkar_pkg::scan_t                    tok_o,
  output logic [KEY_BITS-1:0]                key_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   hit_idx_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   min_idx_o,
  input  pkar_pkg::wr_t                      wr_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   wr_idx_i,
  input  logic [KEY_BITS-1:0]                wr_key_i
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [KEY_BITS-1:0] ent_key_r;
  logic [15:0]         ent_count_r;
  logic [31:0]         ent_start_r;

  pkar_pkg::scan_t     tok_r, tok_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]    min_idx_r, min_idx_nxt;
  logic                used;

  assign used = MY_CNT < used_cnt;

  always_comb begin
    tok_nxt     = tok_i;
    hit_idx_nxt = hit_idx_i;
    min_idx_nxt = min_idx_i;
    if (used && !tok_i.hit && ent_key_r == key_i) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_count = ent_count_r;
      tok_nxt.hit_start = ent_start_r;
      hit_idx_nxt       = MY_IDX;
    end
    if (used && ent_start_r < tok_i.min_start) begin
      tok_nxt.min_start = ent_start_r;
      min_idx_nxt       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_i.vld;
    end
    tok_r.kind      <= tok_nxt.kind;
    tok_r.now       <= tok_nxt.now;
    tok_r.hit       <= tok_nxt.hit;
    tok_r.hit_count <= tok_nxt.hit_count;
    tok_r.hit_start <= tok_nxt.hit_start;
    tok_r.min_start <= tok_nxt.min_start;
    key_r           <= key_i;
    hit_idx_r       <= hit_idx_nxt;
    min_idx_r       <= min_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_i.en && wr_idx_i == MY_IDX) begin
      ent_count_r <= wr_i.count;
      ent_start_r <= wr_i.start;
      if (wr_i.key_we) begin
        ent_key_r <= wr_key_i;
      end
    end
  end

  assign tok_o     = tok_r;
  assign key_o     = key_r;
  assign hit_idx_o = hit_idx_r;
  assign min_idx_o = min_idx_r;

endmodule

// ===== src/per_key_attempt_rate_limiter.sv =====
// Per-key failed-attempt rate limiter.
// Input channel (in_valid/in_ready): kind (check, record failure, clear),
// user key and the current time in seconds. Output channel
// (out_valid/out_ready): one result per item, blocked and entry_found.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 enable,
// 1 max attempts, 2 window length in seconds; write only while idle.
// The table is a row of TABLE_ENTRIES cells. A search token walks the row,
// one cell per cycle, picking up the first key match and the oldest window
// start; the update is written back in the cycle the token leaves the row.
// Each item passes the cell registers, the result register and the output register.
// A new item is taken only once the walk has ended and the result register is empty.
// The next item is taken while a result waits in the output register.
// A stalled receiver holds the output; one further result may wait inside.
// Reset empties the table (fill count zero), disables the limiter, sets
// max attempts to 5 and the window to 300 seconds.
module per_key_attempt_rate_limiter #(
  parameter int TABLE_ENTRIES = 256,
  parameter int KEY_BITS      = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [KEY_BITS-1:0] in_user_key,
  input  logic [31:0]         in_now_seconds,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_blocked,
  output logic                out_entry_found,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES+1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  logic        enable_r;
  logic [15:0] max_r;
  logic [19:0] window_r;
  logic [CNT_W-1:0] used_r;
  logic        busy_r;
  logic        res_vld_r, res_blocked_r, res_found_r;
  logic        out_valid_r, out_blocked_r, out_found_r;

  pkar_pkg::scan_t     tok   [0:TABLE_ENTRIES];
  logic [KEY_BITS-1:0] keys  [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]    hidx  [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]    midx  [0:TABLE_ENTRIES];

  pkar_pkg::wr_t       wr;
  logic [IDX_W-1:0]    wr_idx;
  pkar_pkg::scan_t     fin;
  logic                in_xfer, done, expired, act, blocked, found;

  assign in_ready  = !busy_r && !res_vld_r;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign tok[0].vld       = in_xfer;
  assign tok[0].kind      = in_kind;
  assign tok[0].now       = in_now_seconds;
  assign tok[0].hit       = 1'b0;
  assign tok[0].hit_count = 16'd0;
  assign tok[0].hit_start = 32'd0;
  assign tok[0].min_start = 32'hFFFF_FFFF;
  assign keys[0]          = in_user_key;
  assign hidx[0]          = '0;
  assign midx[0]          = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pkar_cell #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .KEY_BITS     (KEY_BITS),
      .IDX          (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .used_cnt (used_r),
      .tok_i    (tok[g]),
      .key_i    (keys[g]),
      .hit_idx_i(hidx[g]),
      .min_idx_i(midx[g]),
      .tok_o    (tok[g+1]),
      .key_o    (keys[g+1]),
      .hit_idx_o(hidx[g+1]),
      .min_idx_o(midx[g+1]),
      .wr_i     (wr),
      .wr_idx_i (wr_idx),
      .wr_key_i (keys[TABLE_ENTRIES])
    );
  end

  assign fin     = tok[TABLE_ENTRIES];
  assign done    = fin.vld;
  assign expired = (fin.now >= fin.hit_start) &&
                   ((fin.now - fin.hit_start) > {12'd0, window_r});
  assign act     = enable_r &&
                   (fin.kind == pkar_pkg::KIND_CHECK || fin.kind == pkar_pkg::KIND_RECORD);

  always_comb begin
    wr       = '0;
    wr_idx   = hidx[TABLE_ENTRIES];
    blocked  = 1'b0;
    found    = 1'b0;
    if (fin.kind == pkar_pkg::KIND_CLEAR) begin
      found = fin.hit;
      wr.en = done && fin.hit;
    end else if (act && fin.hit) begin
      found = 1'b1;
      wr.en = done;
      if (fin.kind == pkar_pkg::KIND_CHECK) begin
        if (expired) begin
          wr.start = fin.now;
        end else begin
          wr.en    = 1'b0;
          blocked  = fin.hit_count >= max_r;
        end
      end else if (expired) begin
        wr.count = 16'd1;
        wr.start = fin.now;
      end else begin
        wr.start = fin.hit_start;
        wr.count = (fin.hit_count == pkar_pkg::COUNT_MAX) ? fin.hit_count
                                                          : fin.hit_count + 16'd1;
      end
    end else if (act && fin.kind == pkar_pkg::KIND_RECORD) begin
      wr.en     = done;
      wr.key_we = 1'b1;
      wr.count  = 16'd1;
      wr.start  = fin.now;
      wr_idx    = (used_r == FULL) ? midx[TABLE_ENTRIES] : used_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      max_r       <= 16'd5;
      window_r    <= 20'd300;
      used_r      <= '0;
      busy_r      <= 1'b0;
      res_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pkar_pkg::REG_ENABLE: enable_r <= cfg_data[0];
          pkar_pkg::REG_MAX:    max_r    <= cfg_data[15:0];
          pkar_pkg::REG_WINDOW: window_r <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (wr.en && wr.key_we && used_r != FULL) begin
        used_r <= used_r + CNT_W'(1);
      end
      if (done) begin
        res_vld_r <= 1'b1;
      end else if (res_vld_r && (!out_valid_r || out_ready)) begin
        res_vld_r <= 1'b0;
      end
      if (res_vld_r && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_blocked_r <= blocked;
      res_found_r   <= found;
    end
    if (res_vld_r && (!out_valid_r || out_ready)) begin
      out_blocked_r <= res_blocked_r;
      out_found_r   <= res_found_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_blocked     = out_blocked_r;
  assign out_entry_found = out_found_r;

endmodule

// ===== sim/attempt_limit_checker.sv =====
`timescale 1ns / 100ps

module attempt_limit_checker #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_user_key,
  input  logic [31:0] in_now_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_blocked,
  input  logic        out_entry_found,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          verdicts_pending
);

  typedef struct packed {
    logic blocked;
    logic found;
  } verdict_t;

  logic        enabled;
  logic [15:0] attempt_limit;
  logic [19:0] window_len;

  logic [63:0] key_tab   [TABLE_ENTRIES];
  logic [15:0] count_tab [TABLE_ENTRIES];
  logic [31:0] start_tab [TABLE_ENTRIES];
  int          fill;

  verdict_t verdict_q[$];

  assign verdicts_pending = verdict_q.size();

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int lookup(input logic [63:0] key);
    for (int i = 0; i < fill; i++)
      if (key_tab[i] == key) return i;
    return -1;
  endfunction

  function automatic bit lapsed(input int idx, input logic [31:0] now);
    if (now < start_tab[idx]) return 1'b0;
    return (now - start_tab[idx]) > {12'd0, window_len};
  endfunction

  function automatic verdict_t judge_attempt(input logic [1:0] kind, input logic [63:0] key,
                                             input logic [31:0] now);
    verdict_t v;
    int       hit;
    int       victim;
    v   = '0;
    hit = lookup(key);
    if (kind == pkar_pkg::KIND_CLEAR) begin
      if (hit >= 0) begin
        v.found        = 1'b1;
        count_tab[hit] = '0;
        start_tab[hit] = '0;
      end
    end else if ((kind == pkar_pkg::KIND_CHECK || kind == pkar_pkg::KIND_RECORD) &&
                 enabled) begin
      if (hit >= 0) begin
        v.found = 1'b1;
        if (kind == pkar_pkg::KIND_CHECK) begin
          if (lapsed(hit, now)) begin
            count_tab[hit] = '0;
            start_tab[hit] = now;
          end else begin
            v.blocked = count_tab[hit] >= attempt_limit;
          end
        end else if (lapsed(hit, now)) begin
          count_tab[hit] = 16'd1;
          start_tab[hit] = now;
        end else if (count_tab[hit] != pkar_pkg::COUNT_MAX) begin
          count_tab[hit]++;
        end
      end else if (kind == pkar_pkg::KIND_RECORD) begin
        if (fill < TABLE_ENTRIES) begin
          victim = fill;
          fill++;
        end else begin
          victim = 0;
          for (int i = 1; i < TABLE_ENTRIES; i++)
            if (start_tab[i] < start_tab[victim]) victim = i;
        end
        key_tab[victim]   = key;
        count_tab[victim] = 16'd1;
        start_tab[victim] = now;
      end
    end
    return v;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      enabled       = 1'b0;
      attempt_limit = 16'd5;
      window_len    = 20'd300;
      fill          = 0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pkar_pkg::REG_ENABLE: enabled       = cfg_data[0];
          pkar_pkg::REG_MAX:    attempt_limit = cfg_data[15:0];
          pkar_pkg::REG_WINDOW: window_len    = cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        verdict_q.push_back(judge_attempt(in_kind, in_user_key, in_now_seconds));
      if (out_valid && out_ready) begin
        got = '{out_blocked, out_entry_found};
        if (verdict_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = verdict_q.pop_front();
          if (got.blocked !== want.blocked)
            report($sformatf("blocked %b, expected %b", got.blocked, want.blocked));
          if (got.found !== want.found)
            report($sformatf("entry_found %b, expected %b", got.found, want.found));
        end
      end
    end
  end

endmodule

// ===== sim/tb_per_key_attempt_rate_limiter.sv =====
`timescale 1ns / 100ps

module tb_per_key_attempt_rate_limiter;

  localparam int ENTRIES     = 256;
  localparam int SETTLE      = ENTRIES + 40;
  localparam int STALL_LIMIT = 30000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = pkar_pkg::KIND_CHECK;
  logic [63:0] in_user_key = '0;
  logic [31:0] in_now_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_blocked;
  logic        out_entry_found;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = pkar_pkg::REG_ENABLE;
  logic [31:0] cfg_data = '0;

  int          errors;
  int          pending;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;
  int          quiet_cycles = 0;
  logic [63:0] key_pool[320];
  logic [31:0] clock_now = 32'd1000;

  always #2 clk = ~clk;

  per_key_attempt_rate_limiter #(.TABLE_ENTRIES(ENTRIES), .KEY_BITS(64)) dut (.*);

  attempt_limit_checker #(.TABLE_ENTRIES(ENTRIES)) checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_user_key, .in_now_seconds,
    .out_valid, .out_ready, .out_blocked, .out_entry_found,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .verdicts_pending(pending)
  );

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_per_key_attempt_rate_limiter: done, errors");
      $finish;
    end
  end

  task automatic send_attempt(input logic [1:0] kind, input logic [63:0] key,
                              input logic [31:0] now);
    bit taken;
    in_valid = 1'b0;
    while ($urandom_range(99) < send_gap_pct) @(negedge clk);
    in_valid       = 1'b1;
    in_kind        = kind;
    in_user_key    = key;
    in_now_seconds = now;
    do begin
      taken = in_ready;
      @(negedge clk);
    end while (!taken);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    bit taken;
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do begin
      taken = cfg_ready;
      @(negedge clk);
    end while (!taken);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(input logic en, input logic [15:0] lim, input logic [19:0] win);
    write_reg(pkar_pkg::REG_ENABLE, {31'd0, en});
    write_reg(pkar_pkg::REG_MAX, {16'd0, lim});
    write_reg(pkar_pkg::REG_WINDOW, {12'd0, win});
  endtask

  task automatic random_attempts(input int n);
    logic [1:0]  kind;
    logic [63:0] key;
    logic [31:0] now;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      kind = pkar_pkg::KIND_RECORD;
      else if (pick < 80) kind = pkar_pkg::KIND_CHECK;
      else if (pick < 95) kind = pkar_pkg::KIND_CLEAR;
      else                kind = KIND_NONE;
      if ($urandom_range(9) == 0) key = {$urandom, $urandom};
      else if ($urandom_range(1)) key = key_pool[$urandom_range(39)];
      else                        key = key_pool[$urandom_range(319)];
      pick = $urandom_range(99);
      if (pick < 4)       clock_now = clock_now + $urandom_range(200, 2000);
      else if (pick < 60) clock_now = clock_now + $urandom_range(0, 8);
      if (pick >= 96) now = $urandom;
      else            now = clock_now;
      send_attempt(kind, key, now);
    end
  endtask

  initial begin
    for (int i = 0; i < 320; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // disabled after reset: check and record have no effect
    send_attempt(pkar_pkg::KIND_RECORD, key_pool[2], 32'd100);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[2], 32'd100);
    write_reg(pkar_pkg::REG_ENABLE, 32'd1);
    send_attempt(pkar_pkg::KIND_RECORD, key_pool[2], 32'd100);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[2], 32'd101);
    repeat (5) send_attempt(pkar_pkg::KIND_RECORD, key_pool[2], 32'd102);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[2], 32'd400);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[2], 32'd401);
    send_attempt(pkar_pkg::KIND_RECORD, key_pool[2], 32'd800);
    send_attempt(pkar_pkg::KIND_CLEAR, key_pool[2], 32'd801);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[2], 32'd802);
    send_attempt(pkar_pkg::KIND_RECORD, key_pool[0], 32'd0);
    send_attempt(pkar_pkg::KIND_RECORD, key_pool[1], 32'hFFFF_FFFF);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[1], 32'd5);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[0], 32'hFFFF_FFFF);
    send_attempt(KIND_NONE, key_pool[1], 32'd7);
    send_attempt(pkar_pkg::KIND_CLEAR, key_pool[3], 32'd7);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[3], 32'd7);

    setup(1'b1, 16'd0, 20'd0);
    send_attempt(pkar_pkg::KIND_RECORD, key_pool[4], 32'd50);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[4], 32'd50);
    send_attempt(pkar_pkg::KIND_CHECK, key_pool[4], 32'd51);
    random_attempts(180);

    setup(1'b1, 16'hFFFF, 20'hFFFFF);
    send_gap_pct = 54;
    random_attempts(190);

    setup(1'b1, 16'd3, 20'd300);
    send_gap_pct   = 0;
    recv_stall_pct = 54;
    random_attempts(190);

    setup(1'b0, 16'd2, 20'd40);
    send_gap_pct   = 33;
    recv_stall_pct = 33;
    random_attempts(80);

    write_reg(pkar_pkg::REG_ENABLE, 32'd1);
    hold_off = 3000;
    random_attempts(200);
    while (pending != 0) @(negedge clk);
    random_attempts(40);

    setup(1'b1, 16'd1, 20'd20);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_attempts(270);

    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_per_key_attempt_rate_limiter: done, clean");
    else
      $display("tb_per_key_attempt_rate_limiter: done, errors");
    $finish;
  end

endmodule
